// ===== design/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on i_clk, disabled while reset is held
`define BLSE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, disabled while reset is held
`define BLSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/blse_pkg.sv =====
// package: types, codes and sizes of the bounded list stack engine
`timescale 1ns / 1ps
`default_nettype none

package blse_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = 7;
    localparam int DATA_W   = 32;

    typedef enum logic [2:0] {
        CMD_PUSH   = 3'd0,
        CMD_POP    = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_FIND   = 3'd3,
        CMD_CLEAR  = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_EMPTY = 2'd1,
        STS_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [2:0]               command;
        logic signed [DATA_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic [1:0]               status;
        logic                     found;
        logic                     front_valid;
        logic signed [DATA_W-1:0] front_value;
        logic [CNT_W-1:0]         entry_count;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_FRONT,
        ST_RESULT
    } t_state;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic scan;
        logic front;
        logic emit;
    } t_ctrl;

    // status from the datapath to the controller
    typedef struct packed {
        logic is_scan;
        logic scan_done;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== design/blse_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module blse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== design/blse_ctrl.sv =====
// controller state machine of the bounded list stack engine
`timescale 1ns / 1ps
`default_nettype none

module blse_ctrl
    import blse_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire t_dp_sts i_sts,
    output logic         o_busy,
    output t_ctrl        o_ctl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = i_sts.is_scan ? ST_SCAN : ST_FRONT;
            end
            ST_SCAN: begin
                if (i_sts.scan_done) n_state = ST_FRONT;
            end
            ST_FRONT: begin
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ctl  = '0;
        o_busy = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_busy     = 1'b0;
                o_ctl.load = i_start;
            end
            ST_EXEC:   o_ctl.exec  = 1'b1;
            ST_SCAN:   o_ctl.scan  = 1'b1;
            ST_FRONT:  o_ctl.front = 1'b1;
            ST_RESULT: o_ctl.emit  = 1'b1;
            default:   o_busy      = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

// ===== design/blse_dp.sv =====
// datapath: entry store, count, scan pointers and result register
`timescale 1ns / 1ps
`default_nettype none

module blse_dp
    import blse_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_in   i_item,
    input  wire t_ctrl i_ctl,
    output t_dp_sts    o_sts,
    output logic       o_done,
    output t_out       o_result
);

    logic [2:0]        r_cmd,    n_cmd;
    logic [DATA_W-1:0] r_value,  n_value;
    logic [CNT_W-1:0]  r_count,  n_count;
    logic [CNT_W-1:0]  r_rd,     n_rd;
    logic [CNT_W-1:0]  r_wr,     n_wr;
    logic              r_pend,   n_pend;
    logic              r_found,  n_found;
    logic [1:0]        r_status, n_status;
    logic              r_done,   n_done;
    t_out              r_res,    n_res;

    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
    logic [DATA_W-1:0] rdata;
    logic [CNT_W-1:0]  count_m1;
    logic              scan_done;
    logic              match;

    blse_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign count_m1  = r_count - CNT_W'(1);
    assign scan_done = !r_pend && (r_rd == r_count);
    assign match     = (rdata == r_value);

    assign o_sts.is_scan   = (r_cmd == CMD_REMOVE) || (r_cmd == CMD_FIND);
    assign o_sts.scan_done = scan_done;

    // the front read uses the only read port, scanning uses it otherwise
    assign raddr = i_ctl.front ? count_m1[ADDR_W-1:0] : r_rd[ADDR_W-1:0];

    always_comb begin
        n_cmd    = r_cmd;
        n_value  = r_value;
        n_count  = r_count;
        n_rd     = r_rd;
        n_wr     = r_wr;
        n_pend   = r_pend;
        n_found  = r_found;
        n_status = r_status;
        n_res    = r_res;
        n_done   = i_ctl.emit;
        we       = 1'b0;
        waddr    = r_wr[ADDR_W-1:0];
        wdata    = rdata;

        if (i_ctl.load) begin
            n_cmd   = i_item.command;
            n_value = i_item.value;
        end

        if (i_ctl.exec) begin
            n_status = STS_OK;
            n_found  = 1'b0;
            n_rd     = '0;
            n_wr     = '0;
            n_pend   = 1'b0;
            case (r_cmd)
                CMD_PUSH: begin
                    if (r_count == CNT_W'(CAPACITY)) begin
                        n_status = STS_FULL;
                    end else begin
                        we      = 1'b1;
                        waddr   = r_count[ADDR_W-1:0];
                        wdata   = r_value;
                        n_count = r_count + CNT_W'(1);
                    end
                end
                CMD_POP: begin
                    if (r_count == '0) begin
                        n_status = STS_EMPTY;
                    end else begin
                        n_count = count_m1;
                    end
                end
                CMD_CLEAR: n_count = '0;
                default:   n_count = r_count;
            endcase
        end

        if (i_ctl.scan) begin
            // data read last cycle is handled while the next slot is read
            if (r_pend) begin
                if ((r_cmd == CMD_FIND) && match) begin
                    n_found = 1'b1;
                end
                if ((r_cmd == CMD_REMOVE) && !match) begin
                    we    = 1'b1;
                    waddr = r_wr[ADDR_W-1:0];
                    wdata = rdata;
                    n_wr  = r_wr + CNT_W'(1);
                end
            end
            if (r_rd < r_count) begin
                n_rd   = r_rd + CNT_W'(1);
                n_pend = 1'b1;
            end else begin
                n_pend = 1'b0;
            end
            if (scan_done && (r_cmd == CMD_REMOVE)) begin
                n_count = r_wr;
            end
        end

        if (i_ctl.emit) begin
            n_res.status      = r_status;
            n_res.found       = r_found;
            n_res.front_valid = (r_count != '0);
            n_res.front_value = (r_count != '0) ? rdata : '0;
            n_res.entry_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_pend  <= n_pend;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_value  <= n_value;
        r_rd     <= n_rd;
        r_wr     <= n_wr;
        r_found  <= n_found;
        r_status <= n_status;
        r_res    <= n_res;
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

`default_nettype wire

// ===== design/bounded_list_stack_engine.sv =====
// top level of the bounded list stack engine
`timescale 1ns / 1ps
`default_nettype none

// bounded front-access list of up to 64 signed 32-bit entries, stored in
// stack order in a single-port-write, single-port-read ram. an item (command
// and value) is taken when i_start is high and o_busy is low; exactly one
// result item follows, shown on o_result for one cycle with o_done high.
// the receiver cannot stall, so it must take the result in that cycle.
// push, pop, clear and unused codes pass through execute, front read and
// result states; remove and find also walk the stored entries through the ram
// read port, one entry per cycle, between execute and the front read.
// remove compacts the survivors in place through the write port during the
// same walk. o_busy drops in the cycle o_done is shown, so a new item may be
// taken while the previous result is on the ports. there is no clearing pass
// after reset: entries above the count never reach a result.
module bounded_list_stack_engine
    import blse_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_in  i_item,
    output logic      o_busy,
    output logic      o_done,
    output t_out      o_result
);

    t_ctrl   ctl;
    t_dp_sts sts;

    // sequencing: idle, execute, scan, front read, result
    blse_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (sts),
        .o_busy  (o_busy),
        .o_ctl   (ctl)
    );

    // store, count, scan pointers and the registered result
    blse_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_ctl    (ctl),
        .o_sts    (sts),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

// ===== design/blse_checker.sv =====
// port-level checks of the bounded list stack engine and their bind
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module blse_checker
    import blse_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_start,
    input wire logic o_busy,
    input wire logic o_done,
    input wire t_out o_result
);

    `BLSE_ASSERT_NEXT(a_busy_after_accept, i_start && !o_busy, o_busy, "not busy after accept")
    `BLSE_ASSERT_NEXT(a_single_strobe, o_done, !o_done, "result strobe held longer than one cycle")
    `BLSE_ASSERT_NOW(a_count_bound, o_done, o_result.entry_count <= CNT_W'(CAPACITY), "count above capacity")
    `BLSE_ASSERT_NOW(a_front_valid, o_done, o_result.front_valid == (o_result.entry_count != '0), "front valid disagrees with count")
    `BLSE_ASSERT_NOW(a_empty_zero, o_done && !o_result.front_valid, o_result.front_value == '0, "empty store shows a front value")

endmodule

bind bounded_list_stack_engine blse_checker u_blse_checker (.*);

`default_nettype wire

// ===== tb/sv/tb.sv =====
// testbench for the bounded list stack engine: directed table, then random command mix
`timescale 1ns / 1ps

module tb;
    import blse_pkg::*;

    localparam int  HALF_PERIOD = 10;
    localparam int  RESET_CYCLES = 11;
    localparam int  RAND_ITEMS = 500;
    localparam int  STALL_LIMIT = 2000;
    localparam int  DRAIN_CYCLES = 80;

    // command codes the block does not decode
    localparam logic [2:0] CMD_SPARE_A = 3'd5;
    localparam logic [2:0] CMD_SPARE_B = 3'd6;
    localparam logic [2:0] CMD_SPARE_C = 3'd7;

    localparam logic signed [DATA_W-1:0] VMAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] VMIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VNEG = 32'shffff_ffff;
    localparam logic signed [DATA_W-1:0] VODD = 32'sh1234_5678;
    localparam t_out NO_RESULT = '0;

    // one directed row: the item, and a hand-written result where one is given
    typedef struct packed {
        t_in  item;
        logic fixed;
        t_out want;
    } t_row;

    localparam int DIR_N = 24;

    t_row dir_rows [DIR_N] = '{
        // pop, find and remove on the store straight after reset
        '{'{CMD_POP,    32'sd0}, 1'b1, '{STS_EMPTY, 1'b0, 1'b0, 32'sd0, 7'd0}},
        '{'{CMD_FIND,   VMAX},   1'b1, '{STS_OK,    1'b0, 1'b0, 32'sd0, 7'd0}},
        '{'{CMD_REMOVE, VMAX},   1'b1, '{STS_OK,    1'b0, 1'b0, 32'sd0, 7'd0}},
        // value extremes
        '{'{CMD_PUSH,   VMAX},   1'b1, '{STS_OK,    1'b0, 1'b1, VMAX,   7'd1}},
        '{'{CMD_PUSH,   VMIN},   1'b1, '{STS_OK,    1'b0, 1'b1, VMIN,   7'd2}},
        '{'{CMD_PUSH,   32'sd0}, 1'b1, '{STS_OK,    1'b0, 1'b1, 32'sd0, 7'd3}},
        '{'{CMD_PUSH,   VNEG},   1'b1, '{STS_OK,    1'b0, 1'b1, VNEG,   7'd4}},
        '{'{CMD_PUSH,   VMIN},   1'b0, NO_RESULT},
        '{'{CMD_FIND,   VMIN},   1'b1, '{STS_OK,    1'b1, 1'b1, VMIN,   7'd5}},
        '{'{CMD_FIND,   VODD},   1'b1, '{STS_OK,    1'b0, 1'b1, VMIN,   7'd5}},
        // remove with no match leaves the store alone
        '{'{CMD_REMOVE, VODD},   1'b1, '{STS_OK,    1'b0, 1'b1, VMIN,   7'd5}},
        // remove of a value held twice, front included
        '{'{CMD_REMOVE, VMIN},   1'b1, '{STS_OK,    1'b0, 1'b1, VNEG,   7'd3}},
        '{'{CMD_SPARE_A, VMIN},  1'b1, '{STS_OK,    1'b0, 1'b1, VNEG,   7'd3}},
        '{'{CMD_POP,    VMAX},   1'b0, NO_RESULT},
        '{'{CMD_SPARE_B, VNEG},  1'b0, NO_RESULT},
        '{'{CMD_SPARE_C, VMAX},  1'b0, NO_RESULT},
        '{'{CMD_PUSH,   32'sh5555_5555}, 1'b0, NO_RESULT},
        '{'{CMD_PUSH,   32'shaaaa_aaaa}, 1'b0, NO_RESULT},
        '{'{CMD_REMOVE, 32'sd0}, 1'b0, NO_RESULT},
        '{'{CMD_FIND,   VMAX},   1'b0, NO_RESULT},
        '{'{CMD_CLEAR,  VMAX},   1'b1, '{STS_OK,    1'b0, 1'b0, 32'sd0, 7'd0}},
        '{'{CMD_POP,    VNEG},   1'b1, '{STS_EMPTY, 1'b0, 1'b0, 32'sd0, 7'd0}},
        '{'{CMD_PUSH,   32'sd1}, 1'b0, NO_RESULT},
        // removing the only entry empties the store
        '{'{CMD_REMOVE, 32'sd1}, 1'b1, '{STS_OK,    1'b0, 1'b0, 32'sd0, 7'd0}}
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    t_in  i_item = '0;
    logic o_busy;
    logic o_done;
    t_out o_result;

    // travels with the item so the monitor sees it at the accepting edge
    logic hand_fixed = 1'b0;
    t_out hand_want = '0;

    // predictor state: entries in stack order, front at list_len-1
    logic signed [DATA_W-1:0] list_mem [CAPACITY];
    int   list_len = 0;

    t_out pending_results [$];
    int   fail_count = 0;
    int   sent = 0;
    int   stall_cycles = 0;
    bit   idle_on = 1'b1;

    bounded_list_stack_engine DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_item   (i_item),
        .o_busy   (o_busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // applies one item to the predicted store and returns the result it causes
    function automatic t_out list_apply(input t_in it);
        t_out r;
        int   wr;
        r = '0;
        case (it.command)
            CMD_PUSH: begin
                if (list_len >= CAPACITY) begin
                    r.status = STS_FULL;
                end else begin
                    list_mem[list_len] = it.value;
                    list_len++;
                end
            end
            CMD_POP: begin
                if (list_len == 0) begin
                    r.status = STS_EMPTY;
                end else begin
                    list_len--;
                end
            end
            CMD_REMOVE: begin
                // survivors keep their order
                wr = 0;
                for (int rd = 0; rd < list_len; rd++) begin
                    if (list_mem[rd] != it.value) begin
                        list_mem[wr] = list_mem[rd];
                        wr++;
                    end
                end
                list_len = wr;
            end
            CMD_FIND: begin
                for (int i = 0; i < list_len; i++) begin
                    if (list_mem[i] == it.value) begin
                        r.found = 1'b1;
                    end
                end
            end
            CMD_CLEAR: begin
                list_len = 0;
            end
            default: begin
            end
        endcase
        r.front_valid = (list_len != 0);
        if (list_len != 0) begin
            r.front_value = list_mem[list_len-1];
        end
        r.entry_count = CNT_W'(list_len);
        return r;
    endfunction

    task automatic note_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic compare_result(input t_out got, input t_out want);
        if (got.status !== want.status)
            note_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
        if (got.found !== want.found)
            note_mismatch($sformatf("found got %0b want %0b", got.found, want.found));
        if (got.front_valid !== want.front_valid)
            note_mismatch($sformatf("front_valid got %0b want %0b",
                got.front_valid, want.front_valid));
        if (got.front_value !== want.front_value)
            note_mismatch($sformatf("front_value got %0h want %0h",
                got.front_value, want.front_value));
        if (got.entry_count !== want.entry_count)
            note_mismatch($sformatf("entry_count got %0d want %0d",
                got.entry_count, want.entry_count));
    endtask

    // results are checked before a new item is taken at the same edge
    always @(posedge i_clk) begin : monitor
        t_out predicted;
        if (i_rst_n) begin
            if (o_done) begin
                if (pending_results.size() == 0) begin
                    note_mismatch("result with none outstanding");
                end else begin
                    compare_result(o_result, pending_results.pop_front());
                end
            end
            if (i_start && !o_busy) begin
                predicted = list_apply(i_item);
                pending_results.push_back(hand_fixed ? hand_want : predicted);
            end
        end
    end

    // ends a hung run: counts cycles with neither an item taken nor a result shown
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_done) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // holds the item and raises start on most cycles until the block takes it
    task automatic send_item(input t_in item, input logic fixed, input t_out want);
        logic drive;
        i_item     <= item;
        hand_fixed <= fixed;
        hand_want  <= want;
        forever begin
            drive = !(idle_on && ($urandom_range(0, 99) < 24));
            i_start <= drive;
            @(posedge i_clk);
            if (drive && !o_busy) break;
        end
        sent++;
    endtask

    // mostly values from a small pool so finds and removes hit
    function automatic logic signed [DATA_W-1:0] pick_value();
        logic signed [DATA_W-1:0] pool [8];
        pool = '{VMAX, VMIN, 32'sd0, VNEG, 32'sd1, 32'sd7, 32'sh5555_5555, 32'shaaaa_aaaa};
        if ($urandom_range(0, 99) < 60) begin
            return pool[$urandom_range(0, 7)];
        end
        return $urandom;
    endfunction

    function automatic logic [2:0] pick_command();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) return CMD_PUSH;
        if (roll < 55) return CMD_POP;
        if (roll < 70) return CMD_REMOVE;
        if (roll < 88) return CMD_FIND;
        if (roll < 91) return CMD_CLEAR;
        case ($urandom_range(0, 2))
            0: return CMD_SPARE_A;
            1: return CMD_SPARE_B;
            default: return CMD_SPARE_C;
        endcase
    endfunction

    initial begin : stimulus
        int burst;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            send_item(dir_rows[r].item, dir_rows[r].fixed, dir_rows[r].want);
        end

        // random mix; now and then a push burst long enough to hit the full store
        while (sent < DIR_N + RAND_ITEMS) begin
            idle_on = !(sent >= 220 && sent < 320);
            if ($urandom_range(0, 99) < 1) begin
                burst = CAPACITY + $urandom_range(1, 4);
                repeat (burst) begin
                    send_item('{command: CMD_PUSH, value: pick_value()}, 1'b0, NO_RESULT);
                end
            end else begin
                send_item('{command: pick_command(), value: pick_value()}, 1'b0, NO_RESULT);
            end
        end
        i_start <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

// ===== bounded_list_stack_engine.f =====
+incdir+design
design/blse_pkg.sv
design/blse_ram.sv
design/blse_ctrl.sv
design/blse_dp.sv
design/bounded_list_stack_engine.sv
design/blse_checker.sv
tb/sv/tb.sv
